// File: src/sstsw_pkg.sv
package sstsw_pkg;

	localparam int NumWidth   = 16;
	localparam int SegWidth   = 7;
	localparam int AddrWidth  = 8;
	localparam int MagWidth   = 10;
	localparam int DigitWidth = 4;

	localparam logic signed [NumWidth-1:0] NUM_MAX = 16'sd999;
	localparam logic signed [NumWidth-1:0] NUM_MIN = -16'sd99;

	localparam logic [AddrWidth-1:0] BASE_FIRST  = 8'b1100_0000;
	localparam logic [AddrWidth-1:0] BASE_SECOND = 8'b1100_0110;
	localparam logic [AddrWidth-1:0] ADDR_STEP   = 8'd2;

	localparam logic [SegWidth-1:0] SEG_MINUS = 7'b100_0000;
	localparam logic [SegWidth-1:0] SEG_BLANK = 7'b000_0000;

	// Encoded number, ready to go out as up to three beats.
	typedef struct packed {
		logic                 accepted;
		logic [AddrWidth-1:0] base;
		logic [SegWidth-1:0]  seg_u;
		logic [SegWidth-1:0]  seg_t;
		logic [SegWidth-1:0]  seg_h;
	} disp_item_t;

	// Segment pattern of one decimal digit; codes above nine show a minus.
	function automatic logic [SegWidth-1:0] digit_segments(input logic [DigitWidth-1:0] d);
		logic [SegWidth-1:0] seg;
		case (d)
			4'd0:    seg = 7'b011_1111;
			4'd1:    seg = 7'b000_0110;
			4'd2:    seg = 7'b101_1011;
			4'd3:    seg = 7'b100_1111;
			4'd4:    seg = 7'b110_0110;
			4'd5:    seg = 7'b110_1101;
			4'd6:    seg = 7'b111_1101;
			4'd7:    seg = 7'b000_0111;
			4'd8:    seg = 7'b111_1111;
			4'd9:    seg = 7'b110_1111;
			default: seg = SEG_MINUS;
		endcase
		return seg;
	endfunction

endpackage

// File: src/signed_three_digit_seven_segment_writer_core.sv
// Signed three-digit seven-segment writer. Each input beat carries a signed
// 16-bit number and a display select; a number from -99 to 999 leaves as three
// output beats (units, tens, hundreds), each a grid address command byte and a
// seven-segment pattern (bit 0 segment a up to bit 6 segment g), with leading
// zeros blanked and a minus sign in the hundreds place, or in the tens place
// when the tens digit is zero. Addresses start at 0xC0 (select high) or 0xC6
// (select low) and step by two. Any other number leaves as one beat with
// tuser low, tlast high and zero data. The output port moves one beat per
// cycle while m_tready is high; a shown number needs three beats and a
// rejected one needs one. The serializer sets that rate. A number enters an
// input register, is split and encoded by combinational logic, and lands in
// the output register from which the beats are sent; the input register takes
// the next number while the previous one is still going out.
module signed_three_digit_seven_segment_writer_core import sstsw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] number (signed)
	input  logic        s_tuser,   // [0] display_select
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] grid_address, [14:8] segment_code, [15] zero
	output logic        m_tuser,   // [0] accepted
	output logic        m_tlast    // last beat of this number
);

	logic                       valid_s1;
	logic signed [NumWidth-1:0] number_s1;
	logic                       select_s1;
	logic                       emit_ready;
	disp_item_t                 enc_item;

	// Hold the input beat until the serializer takes it.
	assign s_tready = !valid_s1 || emit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			number_s1 <= s_tdata;
			select_s1 <= s_tuser;
		end
	end

	// Split into digits and encode.
	sstsw_encode u_encode (
		.number         (number_s1),
		.display_select (select_s1),
		.item           (enc_item)
	);

	// Send the encoded number out one digit per beat.
	sstsw_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (emit_ready),
		.load_item  (enc_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// File: src/sstsw_encode.sv
module sstsw_encode import sstsw_pkg::*; (
	input  logic signed [NumWidth-1:0] number,
	input  logic                       display_select,
	output disp_item_t                 item
);

	logic                  in_range;
	logic                  neg;
	logic [NumWidth-1:0]   abs_w;
	logic [MagWidth-1:0]   mag;
	logic [15:0]           h_prod;
	logic [DigitWidth-1:0] h;
	logic [10:0]           h_hund;
	logic [6:0]            rem;
	logic [14:0]           t_prod;
	logic [DigitWidth-1:0] t;
	logic [6:0]            t_ten;
	logic [DigitWidth-1:0] u;

	assign in_range = (number <= NUM_MAX) && (number >= NUM_MIN);
	assign neg      = number[NumWidth-1];
	assign abs_w    = neg ? (~number + 16'd1) : number;
	assign mag      = abs_w[MagWidth-1:0];

	// mag / 100 as (mag * 41) >> 12, exact below 1000
	assign h_prod = 16'(mag) * 16'd41;
	assign h      = h_prod[15:12];
	assign h_hund = 11'(h) * 11'd100;
	assign rem    = 7'(11'(mag) - h_hund);

	// rem / 10 as (rem * 205) >> 11, exact below 100
	assign t_prod = 15'(rem) * 15'd205;
	assign t      = t_prod[14:11];
	assign t_ten  = 7'(t) * 7'd10;
	assign u      = 4'(rem - t_ten);

	always_comb begin
		item.accepted = in_range;
		item.base     = display_select ? BASE_FIRST : BASE_SECOND;
		item.seg_u    = digit_segments(u);
		if (neg && (t != 4'd0)) begin
			item.seg_h = SEG_MINUS;
		end else if (h == 4'd0) begin
			item.seg_h = SEG_BLANK;
		end else begin
			item.seg_h = digit_segments(h);
		end
		if (neg && (t == 4'd0)) begin
			item.seg_t = SEG_MINUS;
		end else if ((t == 4'd0) && (h == 4'd0)) begin
			item.seg_t = SEG_BLANK;
		end else begin
			item.seg_t = digit_segments(t);
		end
	end

endmodule

// File: src/sstsw_emit.sv
module sstsw_emit import sstsw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_valid,
	output logic                 load_ready,
	input  disp_item_t           load_item,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,
	output logic                 m_tuser,
	output logic                 m_tlast
);

	typedef enum logic [2:0] {
		BEAT_UNITS    = 3'b001,
		BEAT_TENS     = 3'b010,
		BEAT_HUNDREDS = 3'b100
	} beat_t;

	disp_item_t          item_s2;
	logic                valid_s2;
	beat_t               beat_q;
	logic                last_beat;
	logic                take;
	logic                load;
	logic [AddrWidth-1:0] addr;
	logic [SegWidth-1:0]  seg;

	assign last_beat  = !item_s2.accepted || (beat_q == BEAT_HUNDREDS);
	assign take       = valid_s2 && m_tready;
	assign load_ready = !valid_s2 || (take && last_beat);
	assign load       = load_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			beat_q   <= BEAT_UNITS;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
				beat_q   <= BEAT_UNITS;
			end else if (take) begin
				if (last_beat) begin
					valid_s2 <= 1'b0;
					beat_q   <= BEAT_UNITS;
				end else begin
					beat_q <= (beat_q == BEAT_UNITS) ? BEAT_TENS : BEAT_HUNDREDS;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= load_item;
		end
	end

	always_comb begin
		case (beat_q)
			BEAT_UNITS: begin
				addr = item_s2.base;
				seg  = item_s2.seg_u;
			end
			BEAT_TENS: begin
				addr = item_s2.base + ADDR_STEP;
				seg  = item_s2.seg_t;
			end
			BEAT_HUNDREDS: begin
				addr = item_s2.base + ADDR_STEP + ADDR_STEP;
				seg  = item_s2.seg_h;
			end
			default: begin
				addr = item_s2.base;
				seg  = item_s2.seg_u;
			end
		endcase
		// rejected number: one beat of zeros
		if (!item_s2.accepted) begin
			addr = '0;
			seg  = SEG_BLANK;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, seg, addr};
	assign m_tuser  = item_s2.accepted;
	assign m_tlast  = last_beat;

endmodule

// File: src/sstsw_checker.sv
module sstsw_checker import sstsw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// Offered input beat holds until taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("offered input beat changed before acceptance");

	// Stalled beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled output beat changed");

	// Digits of one number follow each other at addresses two apart.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tlast |=>
			m_tvalid && m_tuser && (m_tdata[7:0] == $past(m_tdata[7:0]) + ADDR_STEP))
		else $error("digit beat missing or address not stepped");

	// Rejected number is a single zero beat.
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 16'd0))
		else $error("rejected beat malformed");

	// Units digit is never blank and never ends the run.
	a_units: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && ((m_tdata[7:0] == BASE_FIRST) || (m_tdata[7:0] == BASE_SECOND))
			|-> !m_tlast && (m_tdata[14:8] != SEG_BLANK))
		else $error("units beat blank or marked last");

endmodule

bind signed_three_digit_seven_segment_writer_core sstsw_checker u_sstsw_checker (.*);
